>>> hdl/cdm_pkg.sv
`default_nettype none
package cdm_pkg;

	// q.30 arithmetic, one guard bit so that 1.0 fits
	localparam int QF = 30;
	localparam int QW = QF + 1;

	localparam logic [QW-1:0] Q_ONE = QW'(1) << QF;
	localparam logic [2*QW-1:0] Q_RND = (2*QW)'(1) << (QF - 1);
	// round(pi/4 * 2^30)
	localparam logic [QW-1:0] PI4 = QW'(843314857);

	localparam int IN_BITS_DEF = 16;
	localparam int OUT_FRAC_BITS_DEF = 14;

	// horner divisors of the taylor series
	localparam int SIN_STEPS = 4;
	localparam int COS_STEPS = 5;
	localparam int SIN_K [SIN_STEPS] = '{72, 42, 20, 6};
	localparam int COS_K [COS_STEPS] = '{90, 56, 30, 12, 2};

	typedef struct packed {
		logic aneg;
		logic bneg;
		logic swap;
		logic zero;
	} flag_t;

	function automatic logic [QW-1:0] qmul(input logic [QW-1:0] a, input logic [QW-1:0] b);
		logic [2*QW-1:0] p;
		p = a * b;
		p = p + Q_RND;
		return p[QF+QW-1:QF];
	endfunction

endpackage
`default_nettype wire

>>> hdl/concentric_disk_map.sv
// concentric square-to-disk map, fully pipelined
// path from accepted input word to output word: front, divider, angle, cosine lane, back
// (the sine lane runs beside the cosine lane; the pipeline depth is independent of IN_BITS)
// throughput: one word per cycle unless the output stalls; the 31-stage divider and the horner steps are all pipelined
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset (arst_n low, asynchronous) clears every valid bit; data registers are not reset
`default_nettype none
module concentric_disk_map import cdm_pkg::*; #(
	parameter int IN_BITS       = IN_BITS_DEF,
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
	localparam int S_TW = ((2*IN_BITS + 7) / 8) * 8,
	localparam int M_TW = ((2*(OUT_FRAC_BITS+2) + 7) / 8) * 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [S_TW-1:0] s_tdata,   // u_frac, v_frac
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [M_TW-1:0]      m_tdata    // disk_x, disk_y
);

	localparam int OW   = OUT_FRAC_BITS + 2;
	localparam int CSBW = $bits(flag_t) + IN_BITS + 1;
	localparam int LIM  = 1 << OUT_FRAC_BITS;

	// whole pipeline moves together; an empty output slot or a taken word lets it advance
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// front: fold to magnitudes, pick radius and smaller side
	logic             fv;
	flag_t            ff;
	logic [IN_BITS:0] frm, fsm;

	cdm_front #(.IN_BITS(IN_BITS)) u_front (
		.clk, .arst_n, .en,
		.in_valid (s_tvalid),
		.u_frac   (s_tdata[IN_BITS-1:0]),
		.v_frac   (s_tdata[2*IN_BITS-1:IN_BITS]),
		.out_valid(fv),
		.flags    (ff),
		.rm       (frm),
		.sm       (fsm)
	);

	// ratio t = round(s / r) in q.30
	logic             dv;
	flag_t            df;
	logic [IN_BITS:0] drm;
	logic [QW-1:0]    dq;

	cdm_div #(.IN_BITS(IN_BITS)) u_div (
		.clk, .arst_n, .en,
		.in_valid (fv),
		.flags_in (ff),
		.rm_in    (frm),
		.sm_in    (fsm),
		.out_valid(dv),
		.flags_out(df),
		.rm_out   (drm),
		.quo      (dq)
	);

	// angle and its square
	logic             v_s1, v_s2;
	flag_t            f_s1, f_s2;
	logic [IN_BITS:0] rm_s1, rm_s2;
	logic [QW-1:0]    th_s1, th_s2, h_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= dv;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1  <= df;
			rm_s1 <= drm;
			th_s1 <= qmul(dq, PI4);
			f_s2  <= f_s1;
			rm_s2 <= rm_s1;
			th_s2 <= th_s1;
			h_s2  <= qmul(th_s1, th_s1);
		end
	end

	// cosine lane also carries flags and radius
	logic            c_v  [COS_STEPS+1];
	logic [QW-1:0]   c_h  [COS_STEPS+1];
	logic [QW-1:0]   c_p  [COS_STEPS+1];
	logic [CSBW-1:0] c_sb [COS_STEPS+1];

	assign c_v[0]  = v_s2;
	assign c_h[0]  = h_s2;
	assign c_p[0]  = Q_ONE;
	assign c_sb[0] = {f_s2, rm_s2};

	for (genvar g = 0; g < COS_STEPS; g++) begin : g_cos
		cdm_step #(.K(COS_K[g]), .SBW(CSBW)) u_step (
			.clk, .arst_n, .en,
			.in_valid (c_v[g]),
			.h_in     (c_h[g]),
			.x_in     (c_p[g]),
			.sb_in    (c_sb[g]),
			.out_valid(c_v[g+1]),
			.h_out    (c_h[g+1]),
			.p_out    (c_p[g+1]),
			.sb_out   (c_sb[g+1])
		);
	end

	// sine lane carries the angle for the final product
	logic          s_v  [SIN_STEPS+1];
	logic [QW-1:0] s_h  [SIN_STEPS+1];
	logic [QW-1:0] s_p  [SIN_STEPS+1];
	logic [QW-1:0] s_sb [SIN_STEPS+1];

	assign s_v[0]  = v_s2;
	assign s_h[0]  = h_s2;
	assign s_p[0]  = Q_ONE;
	assign s_sb[0] = th_s2;

	for (genvar g = 0; g < SIN_STEPS; g++) begin : g_sin
		cdm_step #(.K(SIN_K[g]), .SBW(QW)) u_step (
			.clk, .arst_n, .en,
			.in_valid (s_v[g]),
			.h_in     (s_h[g]),
			.x_in     (s_p[g]),
			.sb_in    (s_sb[g]),
			.out_valid(s_v[g+1]),
			.h_out    (s_h[g+1]),
			.p_out    (s_p[g+1]),
			.sb_out   (s_sb[g+1])
		);
	end

	// sin = th * p, then two stages to line up with the longer cosine lane
	logic          sn_v_s1, sn_v_s2, sn_v_s3;
	logic [QW-1:0] sn_s1, sn_s2, sn_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sn_v_s1 <= 1'b0;
			sn_v_s2 <= 1'b0;
			sn_v_s3 <= 1'b0;
		end else if (en) begin
			sn_v_s1 <= s_v[SIN_STEPS];
			sn_v_s2 <= sn_v_s1;
			sn_v_s3 <= sn_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sn_s1 <= qmul(s_sb[SIN_STEPS], s_p[SIN_STEPS]);
			sn_s2 <= sn_s1;
			sn_s3 <= sn_s2;
		end
	end

	// scale by radius, round, saturate, apply signs
	flag_t            bf;
	logic [IN_BITS:0] brm;
	logic signed [OW-1:0] disk_x, disk_y;

	assign {bf, brm} = c_sb[COS_STEPS];

	cdm_back #(.IN_BITS(IN_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
		.clk, .arst_n, .en,
		.in_valid (c_v[COS_STEPS]),
		.flags    (bf),
		.rm       (brm),
		.sn       (sn_s3),
		.cs       (c_p[COS_STEPS]),
		.out_valid(m_tvalid),
		.disk_x   (disk_x),
		.disk_y   (disk_y)
	);

	assign m_tdata = M_TW'({disk_y, disk_x});

	// both lanes must carry the same word at the join
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		sn_v_s3 == c_v[COS_STEPS])
		else $error("sine and cosine lanes out of step");

	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (disk_x <= LIM && disk_x >= -LIM))
		else $error("disk_x out of range");

	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (disk_y <= LIM && disk_y >= -LIM))
		else $error("disk_y out of range");

	// a disk point never sits on a square corner
	a_not_corner: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !((disk_x == LIM || disk_x == -LIM) && (disk_y == LIM || disk_y == -LIM)))
		else $error("result at a square corner");

endmodule
`default_nettype wire

>>> hdl/cdm_front.sv
`default_nettype none
module cdm_front import cdm_pkg::*; #(
	parameter int IN_BITS = IN_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic [IN_BITS-1:0] u_frac,
	input  wire logic [IN_BITS-1:0] v_frac,
	output logic                    out_valid,
	output flag_t                   flags,
	output logic [IN_BITS:0]        rm,
	output logic [IN_BITS:0]        sm
);

	localparam logic [IN_BITS:0] FULL = (IN_BITS+1)'(1) << IN_BITS;

	logic [IN_BITS:0] two_u, two_v, am, bm;
	logic             aneg, bneg;
	logic             valid_s1;
	flag_t            flags_s1;
	logic [IN_BITS:0] rm_s1, sm_s1;

	always_comb begin
		two_u = {u_frac, 1'b0};
		two_v = {v_frac, 1'b0};
		aneg  = two_u < FULL;
		bneg  = two_v < FULL;
		am    = aneg ? FULL - two_u : two_u - FULL;
		bm    = bneg ? FULL - two_v : two_v - FULL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s1.aneg <= aneg;
			flags_s1.bneg <= bneg;
			flags_s1.swap <= am > bm;
			flags_s1.zero <= (am == '0) && (bm == '0);
			rm_s1         <= (am > bm) ? am : bm;
			sm_s1         <= (am > bm) ? bm : am;
		end
	end

	assign out_valid = valid_s1;
	assign flags     = flags_s1;
	assign rm        = rm_s1;
	assign sm        = sm_s1;

endmodule
`default_nettype wire

>>> hdl/cdm_div.sv
`default_nettype none
module cdm_div import cdm_pkg::*; #(
	parameter int IN_BITS = IN_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire flag_t           flags_in,
	input  wire logic [IN_BITS:0] rm_in,
	input  wire logic [IN_BITS:0] sm_in,
	output logic                 out_valid,
	output flag_t                flags_out,
	output logic [IN_BITS:0]     rm_out,
	output logic [QW-1:0]        quo
);

	// restoring division, one quotient bit per stage
	localparam int NW = IN_BITS + QW;
	localparam int DW = IN_BITS + 1;
	localparam int RW = IN_BITS + 2;

	logic [NW-1:0] num_in;
	logic [RW-1:0] rem_in0;

	logic          v_s  [QW];
	flag_t         f_s  [QW];
	logic [DW-1:0] d_s  [QW];
	logic [NW-1:0] n_s  [QW];
	logic [RW-1:0] r_s  [QW];
	logic [QW-1:0] q_s  [QW];

	assign num_in  = {sm_in, {(NW-DW){1'b0}}} + NW'(rm_in >> 1);
	assign rem_in0 = RW'(num_in[NW-1:QW]);

	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic          v_i;
		flag_t         f_i;
		logic [DW-1:0] d_i;
		logic [NW-1:0] n_i;
		logic [RW-1:0] r_i;
		logic [QW-1:0] q_i;
		logic [RW-1:0] trial;
		logic          ge;

		if (j == 0) begin : g_first
			assign v_i = in_valid;
			assign f_i = flags_in;
			assign d_i = rm_in;
			assign n_i = num_in;
			assign r_i = rem_in0;
			assign q_i = '0;
		end else begin : g_next
			assign v_i = v_s[j-1];
			assign f_i = f_s[j-1];
			assign d_i = d_s[j-1];
			assign n_i = n_s[j-1];
			assign r_i = r_s[j-1];
			assign q_i = q_s[j-1];
		end

		assign trial = {r_i[RW-2:0], n_i[QW-1-j]};
		assign ge    = trial >= RW'(d_i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				f_s[j] <= f_i;
				d_s[j] <= d_i;
				n_s[j] <= n_i;
				r_s[j] <= ge ? trial - RW'(d_i) : trial;
				q_s[j] <= {q_i[QW-2:0], ge};
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign flags_out = f_s[QW-1];
	assign rm_out    = d_s[QW-1];
	assign quo       = q_s[QW-1];

endmodule
`default_nettype wire

>>> hdl/cdm_step.sv
`default_nettype none
module cdm_step import cdm_pkg::*; #(
	parameter int K   = 6,
	parameter int SBW = 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire logic [QW-1:0]  h_in,
	input  wire logic [QW-1:0]  x_in,
	input  wire logic [SBW-1:0] sb_in,
	output logic                out_valid,
	output logic [QW-1:0]       h_out,
	output logic [QW-1:0]       p_out,
	output logic [SBW-1:0]      sb_out
);

	// p = 1 - round(q(h*x) / K), division by reciprocal and one correction
	localparam int RSH = 33;
	localparam logic [RSH:0] RECIP = (RSH+1)'((64'd1 << RSH) / K);
	localparam logic [QW-1:0] KH = QW'(K / 2);
	localparam logic [QW-1:0] KC = QW'(K);

	logic           v_s1, v_s2, v_s3;
	logic [QW-1:0]  h_s1, h_s2, h_s3;
	logic [SBW-1:0] sb_s1, sb_s2, sb_s3;
	logic [QW-1:0]  m_s1, y_s2, est_s2, p_s3;

	logic [QW-1:0]      y;
	logic [QW+RSH:0]    yprod;
	logic [QW-1:0]      rem;

	always_comb begin
		y     = m_s1 + KH;
		yprod = y * RECIP;
		rem   = y_s2 - QW'(est_s2 * KC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1   <= h_in;
			sb_s1  <= sb_in;
			m_s1   <= qmul(h_in, x_in);
			h_s2   <= h_s1;
			sb_s2  <= sb_s1;
			y_s2   <= y;
			est_s2 <= yprod[QW+RSH-1:RSH];
			h_s3   <= h_s2;
			sb_s3  <= sb_s2;
			p_s3   <= Q_ONE - (est_s2 + QW'(rem >= KC));
		end
	end

	assign out_valid = v_s3;
	assign h_out     = h_s3;
	assign p_out     = p_s3;
	assign sb_out    = sb_s3;

endmodule
`default_nettype wire

>>> hdl/cdm_back.sv
`default_nettype none
module cdm_back import cdm_pkg::*; #(
	parameter int IN_BITS       = IN_BITS_DEF,
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire flag_t                      flags,
	input  wire logic [IN_BITS:0]           rm,
	input  wire logic [QW-1:0]              sn,
	input  wire logic [QW-1:0]              cs,
	output logic                            out_valid,
	output logic signed [OUT_FRAC_BITS+1:0] disk_x,
	output logic signed [OUT_FRAC_BITS+1:0] disk_y
);

	localparam int OW = OUT_FRAC_BITS + 2;
	localparam int PW = IN_BITS + 1 + QW;
	localparam int SH = IN_BITS + QF - OUT_FRAC_BITS;
	localparam logic [PW-1:0] RND = PW'(1) << (SH - 1);
	localparam logic [OW-1:0] LIM = OW'(1) << OUT_FRAC_BITS;

	logic          v_s1, v_s2;
	flag_t         f_s1;
	logic [PW-1:0] px_s1, py_s1;
	logic [OW-1:0] x_s2, y_s2;

	logic [PW-1:0] sx, sy;
	logic [OW-1:0] mx, my;

	always_comb begin
		sx = px_s1 + RND;
		sy = py_s1 + RND;
		mx = sx[PW-1:SH];
		my = sy[PW-1:SH];
		if (mx > LIM) mx = LIM;
		if (my > LIM) my = LIM;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1  <= flags;
			px_s1 <= rm * (flags.swap ? cs : sn);
			py_s1 <= rm * (flags.swap ? sn : cs);
			if (f_s1.zero) begin
				x_s2 <= '0;
				y_s2 <= '0;
			end else begin
				x_s2 <= f_s1.aneg ? OW'(0) - mx : mx;
				y_s2 <= f_s1.bneg ? OW'(0) - my : my;
			end
		end
	end

	assign out_valid = v_s2;
	assign disk_x    = x_s2;
	assign disk_y    = y_s2;

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

	localparam int IN_W    = 16;
	localparam int OUT_F   = 14;
	localparam int OUT_W   = OUT_F + 2;
	localparam int LATENCY = 51;
	// longest quiet stretch: pipeline latency plus the longest random stall, many times over
	localparam int QUIET_LIMIT = 20000;

	localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
	localparam logic [63:0] HALF_Q30 = 64'd1 << 29;
	localparam logic [63:0] PI4_Q30  = 64'd843314857;

	typedef struct packed {
		logic [15:0] y;
		logic [15:0] x;
	} disk_pt_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // u_frac, v_frac
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // disk_x, disk_y

	disk_pt_t disk_pt_q[$];
	int       n_errors;
	int       quiet_cycles;
	int       send_idle_pct;
	int       recv_stall_pct;

	concentric_disk_map dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// q.30 product with rounding
	function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
		return (a * b + HALF_Q30) >> 30;
	endfunction

	function automatic logic [63:0] div_round(input logic [63:0] a, input logic [63:0] k);
		return (a + k / 2) / k;
	endfunction

	// radius times a q.30 trig value, rounded to the output scale and clamped to one
	function automatic logic [15:0] scale_mag(input logic [63:0] rad, input logic [63:0] val);
		logic [63:0] m;
		m = (rad * val + (64'd1 << (IN_W + 29 - OUT_F))) >> (IN_W + 30 - OUT_F);
		if (m > (64'd1 << OUT_F))
			m = 64'd1 << OUT_F;
		return m[15:0];
	endfunction

	function automatic disk_pt_t map_to_disk(input logic [15:0] u, input logic [15:0] v);
		logic [63:0] full, am, bm, rm, sm, t, th, h, p, sn, cs;
		logic [15:0] xm, ym;
		logic        aneg, bneg;
		disk_pt_t    pt;
		full = 64'd1 << IN_W;
		aneg = (2 * 64'(u)) < full;
		bneg = (2 * 64'(v)) < full;
		am = aneg ? full - 2 * 64'(u) : 2 * 64'(u) - full;
		bm = bneg ? full - 2 * 64'(v) : 2 * 64'(v) - full;
		if (am == 0 && bm == 0) begin
			pt.x = '0;
			pt.y = '0;
			return pt;
		end
		// ties take the b branch
		if (am > bm) begin
			rm = am;
			sm = bm;
		end else begin
			rm = bm;
			sm = am;
		end
		t  = ((sm << 30) + rm / 2) / rm;
		th = q30_mul(t, PI4_Q30);
		h  = q30_mul(th, th);
		// sine series, horner form
		p  = ONE_Q30 - div_round(h, 72);
		p  = ONE_Q30 - div_round(q30_mul(h, p), 42);
		p  = ONE_Q30 - div_round(q30_mul(h, p), 20);
		p  = ONE_Q30 - div_round(q30_mul(h, p), 6);
		sn = q30_mul(th, p);
		// cosine series
		p  = ONE_Q30 - div_round(h, 90);
		p  = ONE_Q30 - div_round(q30_mul(h, p), 56);
		p  = ONE_Q30 - div_round(q30_mul(h, p), 30);
		p  = ONE_Q30 - div_round(q30_mul(h, p), 12);
		cs = ONE_Q30 - div_round(q30_mul(h, p), 2);
		if (am > bm) begin
			xm = scale_mag(rm, cs);
			ym = scale_mag(rm, sn);
		end else begin
			xm = scale_mag(rm, sn);
			ym = scale_mag(rm, cs);
		end
		pt.x = aneg ? 16'(-xm) : xm;
		pt.y = bneg ? 16'(-ym) : ym;
		return pt;
	endfunction

	// one word in, prediction queued when the handshake completes
	// tvalid stays up at the following falling edge; the next send replaces or drops it, or the caller drops it
	task automatic send_sample(input logic [15:0] u, input logic [15:0] v);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {v, u};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		disk_pt_q.push_back(map_to_disk(u, v));
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		logic [15:0] u, v;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: begin
					// on the diagonal, ties and near ties
					u = 16'($urandom);
					v = ($urandom_range(1)) ? u : 16'(-u);
					v = v + 16'($urandom_range(2)) - 16'd1;
				end
				1: begin
					// u near the center, v near its minimum or random
					u = 16'h8000 + 16'($urandom_range(8)) - 16'd4;
					v = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom);
				end
				default: begin
					u = 16'($urandom);
					v = 16'($urandom);
				end
			endcase
			send_sample(u, v);
		end
	endtask

	task automatic test_directed;
		send_sample(16'h8000, 16'h8000);   // center
		send_sample(16'h0000, 16'h0000);   // corner, both at minus one
		send_sample(16'h0000, 16'h8000);
		send_sample(16'h8000, 16'h0000);
		send_sample(16'hffff, 16'hffff);
		send_sample(16'hffff, 16'h0000);
		send_sample(16'h0000, 16'hffff);
		send_sample(16'hffff, 16'h8000);
		send_sample(16'h8000, 16'hffff);
		send_sample(16'hc000, 16'hc000);   // equal magnitudes
		send_sample(16'h4000, 16'hc000);
		send_sample(16'hc000, 16'h4000);
		send_sample(16'h4000, 16'h4000);
		send_sample(16'h8001, 16'h8000);
		send_sample(16'h8000, 16'h7fff);
		send_sample(16'h5555, 16'haaaa);
		send_sample(16'haaaa, 16'h5555);
		send_sample(16'h0001, 16'hfffe);
	endtask

	task automatic test_no_idling;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_random(400);
	endtask

	task automatic test_sender_idle;
		send_idle_pct  = 80;
		recv_stall_pct = 0;
		send_random(350);
	endtask

	task automatic test_receiver_stall;
		send_idle_pct  = 0;
		recv_stall_pct = 80;
		send_random(400);
	endtask

	task automatic test_both_idle;
		send_idle_pct  = 32;
		recv_stall_pct = 32;
		send_random(400);
	endtask

	// result side: random stall, compare each word with the oldest prediction
	always @(negedge clk)
		m_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		disk_pt_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (disk_pt_q.size() == 0) begin
				$error("unexpected word: disk_x %0d disk_y %0d",
					$signed(got.x), $signed(got.y));
				n_errors++;
			end else begin
				want = disk_pt_q.pop_front();
				if (got.x !== want.x) begin
					$error("disk_x expected %0d actual %0d", $signed(want.x), $signed(got.x));
					n_errors++;
				end
				if (got.y !== want.y) begin
					$error("disk_y expected %0d actual %0d", $signed(want.y), $signed(got.y));
					n_errors++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		n_errors       = 0;
		quiet_cycles   = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_no_idling();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		s_tvalid <= 1'b0;

		recv_stall_pct = 0;
		while (disk_pt_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
hdl/cdm_pkg.sv
hdl/cdm_front.sv
hdl/cdm_div.sv
hdl/cdm_step.sv
hdl/cdm_back.sv
hdl/concentric_disk_map.sv
bench/tb_top.sv
